/* hdl/rcf_pkg.sv */
package rcf_pkg;

    // register indexes of the configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ABOVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BELOW   = 3'd4;

    // request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // reset values
    localparam logic [11:0]           WIDTH_RST    = 12'd640;
    localparam logic [15:0]           HEIGHT_RST   = 16'd480;
    localparam logic [CFG_DATA_W-1:0] COEF_ID_RST  = 48'h0000_2000_0000;

    // arithmetic widths: 9-bit signed pixel times 16-bit coefficient, nine of them
    localparam int COEF_W = 16;
    localparam int PROD_W = 25;
    localparam int SUM_W  = 29;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_frame;
    } out_item_t;

    // index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] pix_t;

    // one neighbourhood ready for the arithmetic, taps outside the image zeroed
    typedef struct packed {
        pix_t [8:0] tap;
        logic       last;
    } win_t;

endpackage

/* hdl/rcf_ram.sv */
module rcf_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* hdl/rgb_conv3x3_filter_core.sv */
// 3x3 rgb convolution, zero padded, one request per clock while out_ready holds
// path: a request moves through the line store read, the window and fifo push,
//   the products, and sum/round/clamp into the output register
// throughput: one request and one result per cycle unless out_ready stalls;
//   a row end gives two from one request, absorbed by an 8-entry window fifo
// reset: asynchronous active low; size 640x480, identity kernel, frame restarts
module rgb_conv3x3_filter_core
    import rcf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (CW > 12) ? CW : 12;
    localparam int FIFO_D = 8;
    localparam int FP_W   = $clog2(FIFO_D);
    localparam int CNT_W  = FP_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(2 ** (FRAC_BITS - 1));

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0]                 width_reg;
    logic [15:0]                 height_reg;
    logic [2:0][CFG_DATA_W-1:0]  coef_reg;
    logic                        size_write;

    assign size_write = cfg_write &&
                        (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            coef_reg[0] <= '0;
            coef_reg[1] <= COEF_ID_RST;
            coef_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data[11:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data[15:0];
                REG_COEF_ABOVE:   coef_reg[0] <= cfg_data;
                REG_COEF_MIDDLE:  coef_reg[1] <= cfg_data;
                REG_COEF_BELOW:   coef_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // effective frame size: zero counts as one, width capped at the line store depth
    logic [EW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic          h_ge2;

    always_comb
    begin
        if (width_reg == 12'd0)
            eff_w = EW'(1);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_reg);
        eff_h = (height_reg == 16'd0) ? 16'd1 : height_reg;
        h_ge2 = height_reg >= 16'd2;
    end

    // ------------------------------------------------------------------
    // position tracking, decided when a request is accepted
    // ------------------------------------------------------------------
    logic [AW-1:0] cx_reg, cx_next;      // next pixel column
    logic [15:0]   cy_reg, cy_next;      // next pixel row
    logic          drain_reg, drain_next; // final row waiting for flush requests
    logic [AW-1:0] fcol_reg, fcol_next;  // column the next flush delivers

    logic acc, is_flush, pix_go, flush_go;
    logic last_col, last_row, fl_last;

    assign acc      = in_valid && in_ready;
    assign is_flush = in_data.opcode == OP_FLUSH;
    assign pix_go   = acc && !is_flush && !drain_reg;
    assign flush_go = acc && is_flush && drain_reg;
    assign last_col = (EW'(cx_reg) + EW'(1)) == eff_w;
    assign last_row = cy_reg >= (eff_h - 16'd1);
    assign fl_last  = (EW'(fcol_reg) + EW'(1)) == eff_w;

    always_comb
    begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        drain_next = drain_reg;
        fcol_next  = fcol_reg;
        if (size_write)
        begin
            // a new frame size restarts the frame
            cx_next    = '0;
            cy_next    = '0;
            drain_next = 1'b0;
            fcol_next  = '0;
        end
        else if (pix_go)
        begin
            if (last_col)
            begin
                cx_next = '0;
                if (last_row)
                begin
                    cy_next    = '0;
                    drain_next = 1'b1;
                    fcol_next  = '0;
                end
                else
                begin
                    cy_next = cy_reg + 16'd1;
                end
            end
            else
            begin
                cx_next = cx_reg + AW'(1);
            end
        end
        else if (flush_go)
        begin
            if (fl_last)
            begin
                drain_next = 1'b0;
                fcol_next  = '0;
            end
            else
            begin
                fcol_next = fcol_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            drain_reg <= 1'b0;
            fcol_reg  <= '0;
        end
        else
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            drain_reg <= drain_next;
            fcol_reg  <= fcol_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: accepted request, line store data arriving
    // ------------------------------------------------------------------
    logic          s1_pix_reg, s1_fl_reg;
    pix_t          s1_px_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_row_ok_reg, s1_top_ok_reg, s1_ge1_reg, s1_ge2_reg, s1_lastcol_reg;
    logic          s1_left_ok_reg, s1_right_ok_reg, s1_h2_reg, s1_fl_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg <= 1'b0;
            s1_fl_reg  <= 1'b0;
        end
        else
        begin
            s1_pix_reg <= pix_go;
            s1_fl_reg  <= flush_go;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg       <= {in_data.blue_in, in_data.green_in, in_data.red_in};
        s1_addr_reg     <= cx_reg;
        s1_row_ok_reg   <= cy_reg >= 16'd1;
        s1_top_ok_reg   <= cy_reg >= 16'd2;
        s1_ge1_reg      <= cx_reg >= AW'(1);
        s1_ge2_reg      <= cx_reg >= AW'(2);
        s1_lastcol_reg  <= last_col;
        s1_left_ok_reg  <= fcol_reg != '0;
        s1_right_ok_reg <= !fl_last;
        s1_h2_reg       <= h_ge2;
        s1_fl_last_reg  <= fl_last;
    end

    // line stores: port a reads the pixel column or the flush right neighbour,
    // port b the flush centre column
    logic [AW-1:0] raddr_a, raddr_b;
    pix_t          ram_up_a, ram_up_b, ram_lo_a, ram_lo_b;
    pix_t          up_wdata;

    assign raddr_a = is_flush ? (fcol_reg + AW'(1)) : cx_reg;
    assign raddr_b = fcol_reg;

    rcf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_upper
    (
        .clk     (clk),
        .we      (s1_pix_reg),
        .waddr   (s1_addr_reg),
        .wdata   (up_wdata),
        .raddr_a (raddr_a),
        .rdata_a (ram_up_a),
        .raddr_b (raddr_b),
        .rdata_b (ram_up_b)
    );

    rcf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_lower
    (
        .clk     (clk),
        .we      (s1_pix_reg),
        .waddr   (s1_addr_reg),
        .wdata   (s1_px_reg),
        .raddr_a (raddr_a),
        .rdata_a (ram_lo_a),
        .raddr_b (raddr_b),
        .rdata_b (ram_lo_b)
    );

    // bypass: a read in the same cycle as a write to the same column sees the new data
    logic fwd_a_reg, fwd_b_reg;
    pix_t fwd_up_reg, fwd_lo_reg;
    pix_t up_rd_a, lo_rd_a, up_rd_b, lo_rd_b;

    assign up_rd_a  = fwd_a_reg ? fwd_up_reg : ram_up_a;
    assign lo_rd_a  = fwd_a_reg ? fwd_lo_reg : ram_lo_a;
    assign up_rd_b  = fwd_b_reg ? fwd_up_reg : ram_up_b;
    assign lo_rd_b  = fwd_b_reg ? fwd_lo_reg : ram_lo_b;
    assign up_wdata = lo_rd_a;

    always_ff @(posedge clk)
    begin
        fwd_a_reg  <= s1_pix_reg && (s1_addr_reg == raddr_a);
        fwd_b_reg  <= s1_pix_reg && (s1_addr_reg == raddr_b);
        fwd_up_reg <= up_wdata;
        fwd_lo_reg <= s1_px_reg;
    end

    // 3x3 window, [row][col], col 2 newest
    pix_t [2:0][2:0] win_reg, win_next;
    pix_t            fl_prev_up_reg, fl_prev_lo_reg;

    always_comb
    begin
        win_next = win_reg;
        if (s1_pix_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = up_rd_a;
            win_next[1][2] = lo_rd_a;
            win_next[2][2] = s1_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fl_reg)
        begin
            fl_prev_up_reg <= up_rd_b;
            fl_prev_lo_reg <= lo_rd_b;
        end
    end

    // neighbourhoods: a centred on window col 1, b on col 2 at the row end,
    // f for a final row flush
    win_t desc_a, desc_b, desc_f;
    pix_t [2:0] fl_up, fl_lo;
    logic [2:0] fl_ok;
    logic       push_a, push_b, push_f;

    always_comb
    begin
        desc_a = '0;
        desc_b = '0;
        desc_f = '0;
        fl_up  = {up_rd_a, up_rd_b, fl_prev_up_reg};
        fl_lo  = {lo_rd_a, lo_rd_b, fl_prev_lo_reg};
        fl_ok  = {s1_right_ok_reg, 1'b1, s1_left_ok_reg};
        for (int r = 0; r < 3; r++)
        begin
            for (int d = 0; d < 3; d++)
            begin
                if ((r != 0 || s1_top_ok_reg) && (d != 0 || s1_ge2_reg))
                    desc_a.tap[3 * r + d] = win_next[r][d];
                if ((r != 0 || s1_top_ok_reg) && (d != 0 || s1_ge1_reg) && d != 2)
                    desc_b.tap[3 * r + d] = win_next[r][d + 1];
            end
        end
        for (int d = 0; d < 3; d++)
        begin
            if (fl_ok[d] && s1_h2_reg)
                desc_f.tap[d] = fl_up[d];
            if (fl_ok[d])
                desc_f.tap[3 + d] = fl_lo[d];
        end
        desc_f.last = s1_fl_last_reg;
        push_a = s1_pix_reg && s1_row_ok_reg && s1_ge1_reg;
        push_b = s1_pix_reg && s1_row_ok_reg && s1_lastcol_reg;
        push_f = s1_fl_reg;
    end

    // ------------------------------------------------------------------
    // window fifo, up to two pushes and one pop a cycle
    // ------------------------------------------------------------------
    win_t             fifo_reg [FIFO_D];
    logic [FP_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       n_push;
    win_t             push_first;
    logic             pop, adv;
    logic [CNT_W:0]   credit;

    always_comb
    begin
        n_push     = 2'(push_a) + 2'(push_b) + 2'(push_f);
        push_first = push_a ? desc_a : (push_b ? desc_b : desc_f);
        count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);
        // room for whatever stage 1 and the next request may still push
        credit     = {1'b0, count_reg} + ((s1_pix_reg || s1_fl_reg) ?
                     (CNT_W + 1)'(4) : (CNT_W + 1)'(2));
    end

    assign in_ready = credit <= (CNT_W + 1)'(FIFO_D);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= push_first;
        if (n_push == 2'd2)
            fifo_reg[wr_ptr_reg + FP_W'(1)] <= desc_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FP_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + FP_W'(pop);
            count_reg  <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // arithmetic: products, then sum, round and clamp into the output register
    // ------------------------------------------------------------------
    logic                            out_valid_reg;
    out_item_t                       out_data_reg;
    logic                            c1_valid_reg, c1_last_reg;
    logic signed [8:0][2:0][PROD_W-1:0] prod_reg, prod_next;
    win_t                            head;
    logic [2:0][7:0]                 chan;

    assign adv  = !out_valid_reg || out_ready;
    assign pop  = adv && (count_reg != '0);
    assign head = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int d = 0; d < 3; d++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_next[3 * r + d][c] = PROD_W'(
                        $signed({1'b0, head.tap[3 * r + d][c]}) *
                        $signed(coef_reg[r][COEF_W * d +: COEF_W]));
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] acc_sum;
        logic signed [SUM_W-1:0] q;
        for (int c = 0; c < 3; c++)
        begin
            acc_sum = ROUND_C;
            // each product is a signed field, extend it with its sign
            for (int k = 0; k < 9; k++)
                acc_sum = acc_sum + SUM_W'($signed(prod_reg[k][c]));
            q = acc_sum >>> FRAC_BITS;
            if (q < 0)
                chan[c] = 8'd0;
            else if (q > SUM_W'(255))
                chan[c] = 8'd255;
            else
                chan[c] = q[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg  <= count_reg != '0;
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg                   <= prod_next;
            c1_last_reg                <= head.last;
            out_data_reg.red_out       <= chan[0];
            out_data_reg.green_out     <= chan[1];
            out_data_reg.blue_out      <= chan[2];
            out_data_reg.last_of_frame <= c1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
